// File: sv/mbba_pkg.sv
// Package: shared widths, command and status codes, payload types for the bump allocator.
`timescale 1ns / 1ps
package mbba_pkg;

	localparam int CAP_W          = 25;
	localparam int IDX_W          = 4;
	localparam int CMD_W          = 2;
	localparam int STAT_W         = 2;
	localparam int MAX_BLOCKS_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1048576);

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECYCLE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_BLOCK  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [CAP_W-1:0] request_size;
	} in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  block_index;
		logic [CAP_W-1:0]  region_offset;
		logic [CAP_W-1:0]  region_size;
		logic              block_opened;
	} out_t;

endpackage

// File: sv/multi_block_bump_allocator_core.sv
// Top level: multi-block bump allocator with sequential block walk.
`timescale 1ns / 1ps
// One transaction in, one result out. Recycle, free and unused commands go straight to the
// emit state. An allocate command checks the size against the capacity and, if it fits, walks
// the open blocks from the current one, testing each block's fill for a fit, and opens a new
// block when the walk ends without one (or reports none left); the walk is paced by the
// single adder-comparator and the registered read of the fill memory. The result enters
// the output register on the return to idle, and that register holds it under stall; a
// result still stalled there delays the next one and so the next acceptance. No clearing
// pass after reset: per-block valid bits make an emptied block read as zero fill.
module multi_block_bump_allocator_core #(
	parameter int MAX_BLOCKS = mbba_pkg::MAX_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  mbba_pkg::in_t                in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mbba_pkg::out_t               out_data,
	input  logic                         cfg_we,
	input  logic [mbba_pkg::CAP_W-1:0]   cfg_wdata
);
	import mbba_pkg::*;

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int OW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SIZE = 6'b000010,
		S_READ = 6'b000100,
		S_FIT  = 6'b001000,
		S_OPEN = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t                state_q;
	logic [CAP_W-1:0]      cap_q;
	logic [CAP_W-1:0]      req_q;
	logic [IW-1:0]         cur_q;
	logic [IW-1:0]         current_q;
	logic [OW-1:0]         open_q;
	logic [MAX_BLOCKS-1:0] vld_q;
	logic [CAP_W-1:0]      fill_mem [MAX_BLOCKS];
	logic [CAP_W-1:0]      rd_q;
	logic                  rd_vld_q;
	out_t                  res_q;
	logic                  out_valid_q;
	out_t                  out_data_q;

	logic [CAP_W-1:0] fill_cur;
	logic [CAP_W-1:0] unit_a;
	logic [CAP_W:0]   unit_sum;
	logic             unit_fits;
	logic [OW-1:0]    cur_nxt;
	logic             mem_we;
	logic [IW-1:0]    mem_wa;
	logic [CAP_W-1:0] mem_wd;
	logic             slot_free;

	assign fill_cur  = rd_vld_q ? rd_q : '0;
	assign unit_a    = (state_q == S_SIZE) ? '0 : fill_cur;
	assign unit_sum  = {1'b0, unit_a} + {1'b0, req_q};
	assign unit_fits = unit_sum <= {1'b0, cap_q};
	assign cur_nxt   = OW'(cur_q) + OW'(1);
	assign slot_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_q;
		mem_wd = unit_sum[CAP_W-1:0];
		if (state_q == S_FIT && unit_fits) begin
			mem_we = 1'b1;
		end else if (state_q == S_OPEN && open_q < OW'(MAX_BLOCKS)) begin
			mem_we = 1'b1;
			mem_wa = IW'(open_q);
			mem_wd = req_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fill_mem[mem_wa] <= mem_wd;
		end
		if (state_q == S_READ) begin
			rd_q <= fill_mem[cur_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			current_q   <= '0;
			open_q      <= '0;
			vld_q       <= '0;
			cur_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
			req_q       <= '0;
			res_q       <= '0;
			out_data_q  <= '0;
		end else begin
			if (state_q == S_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
				out_data_q  <= res_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data.request_size;
						res_q <= '0;
						case (in_data.command)
							CMD_ALLOC: begin
								state_q <= S_SIZE;
							end
							CMD_RECYCLE: begin
								vld_q     <= '0;
								current_q <= '0;
								state_q   <= S_EMIT;
							end
							CMD_FREE: begin
								vld_q     <= '0;
								current_q <= '0;
								open_q    <= '0;
								state_q   <= S_EMIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SIZE: begin
					cur_q <= current_q;
					if (!unit_fits) begin
						res_q.status <= STAT_TOO_LARGE;
						state_q      <= S_EMIT;
					end else if (OW'(current_q) < open_q) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_OPEN;
					end
				end
				S_READ: begin
					rd_vld_q <= vld_q[cur_q];
					state_q  <= S_FIT;
				end
				S_FIT: begin
					if (unit_fits) begin
						current_q           <= cur_q;
						res_q.block_index   <= IDX_W'(cur_q);
						res_q.region_offset <= fill_cur;
						res_q.region_size   <= req_q;
						state_q             <= S_EMIT;
					end else if (cur_nxt < open_q) begin
						cur_q   <= IW'(cur_nxt);
						state_q <= S_READ;
					end else begin
						state_q <= S_OPEN;
					end
				end
				S_OPEN: begin
					if (open_q < OW'(MAX_BLOCKS)) begin
						current_q          <= IW'(open_q);
						open_q             <= open_q + OW'(1);
						res_q.block_index  <= IDX_W'(open_q);
						res_q.region_size  <= req_q;
						res_q.block_opened <= 1'b1;
					end else begin
						current_q    <= IW'(MAX_BLOCKS - 1);
						res_q.status <= STAT_NO_BLOCK;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/mbba_checker.sv
// Checker: port-level properties of the bump allocator, bound to the top level.
`timescale 1ns / 1ps
module mbba_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input mbba_pkg::out_t               out_data
);
	import mbba_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed or dropped under stall");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STAT_OK |->
		out_data.block_index == '0 && out_data.region_offset == '0 &&
		out_data.region_size == '0 && !out_data.block_opened)
		else $error("failed transaction carries nonzero fields");

	a_open_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.block_opened |->
		out_data.status == STAT_OK && out_data.region_offset == '0)
		else $error("new block granted at nonzero offset");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while busy");

endmodule

bind multi_block_bump_allocator_core mbba_checker u_mbba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// File: sim/testbench.sv
// Testbench for the bump allocator: random and directed transactions with result checks.
`timescale 1ns / 1ps
module testbench;
	import mbba_pkg::*;

	localparam int NBLK = MAX_BLOCKS_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [CAP_W-1:0] SIZE_TOP = CAP_W'(16777216);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	// allocator state mirror
	logic [CAP_W-1:0] cap_m;
	logic [CAP_W-1:0] fill_lvl [NBLK];
	int walk_blk;
	int open_cnt;

	in_t pend_q[$];
	out_t grant_q[$];

	int n_queued, n_accepted, n_results, n_errors, n_cfg;
	int n_grant, n_oversize, n_exhausted, n_opened, n_clear;
	int gap_left, burst_left, stall_mode, stall_left;
	bit send_now;

	multi_block_bump_allocator_core #(.MAX_BLOCKS(NBLK)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic out_t alloc_predict(in_t t);
		out_t r;
		int b;
		bit fit;
		r = '0;
		fit = 1'b0;
		case (t.command)
			CMD_RECYCLE: begin
				for (int i = 0; i < NBLK; i++) fill_lvl[i] = '0;
				walk_blk = 0;
				n_clear++;
			end
			CMD_FREE: begin
				for (int i = 0; i < NBLK; i++) fill_lvl[i] = '0;
				walk_blk = 0;
				open_cnt = 0;
				n_clear++;
			end
			CMD_ALLOC: begin
				if (t.request_size > cap_m) begin
					r.status = STAT_TOO_LARGE;
					n_oversize++;
				end else begin
					b = walk_blk;
					while (!fit && b < open_cnt) begin
						if ({1'b0, fill_lvl[b]} + {1'b0, t.request_size} <= {1'b0, cap_m})
							fit = 1'b1;
						else
							b++;
					end
					if (!fit) begin
						if (open_cnt >= NBLK) begin
							walk_blk = NBLK - 1;
							r.status = STAT_NO_BLOCK;
							n_exhausted++;
						end else begin
							b = open_cnt;
							fill_lvl[b] = '0;
							open_cnt++;
							r.block_opened = 1'b1;
							n_opened++;
							fit = 1'b1;
						end
					end
					if (fit) begin
						walk_blk = b;
						r.status = STAT_OK;
						r.block_index = IDX_W'(b);
						r.region_offset = fill_lvl[b];
						r.region_size = t.request_size;
						fill_lvl[b] = fill_lvl[b] + t.request_size;
						n_grant++;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_result(out_t got);
		out_t want;
		if (grant_q.size() == 0) begin
			n_errors++;
			if (n_errors <= 10)
				$display("unexpected result: st %0d blk %0d off %0d sz %0d op %0d",
					got.status, got.block_index, got.region_offset, got.region_size,
					got.block_opened);
		end else begin
			want = grant_q.pop_front();
			n_results++;
			if (got.status !== want.status || got.block_index !== want.block_index ||
					got.region_offset !== want.region_offset ||
					got.region_size !== want.region_size ||
					got.block_opened !== want.block_opened) begin
				n_errors++;
				if (n_errors <= 10) begin
					$write("mismatch #%0d: exp st %0d blk %0d off %0d sz %0d op %0d,",
						n_results, want.status, want.block_index, want.region_offset,
						want.region_size, want.block_opened);
					$display(" got st %0d blk %0d off %0d sz %0d op %0d",
						got.status, got.block_index, got.region_offset,
						got.region_size, got.block_opened);
				end
			end
		end
	endtask

	// driver: bursts of transactions separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			send_now = in_valid;
			if (in_valid && !in_stall) begin
				grant_q = {grant_q, alloc_predict(in_data)};
				n_accepted++;
				send_now = 1'b0;
			end
			if (!send_now) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_q.size() > 0) begin
					in_data <= pend_q.pop_front();
					send_now = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			in_valid <= send_now;
		end
	end

	// monitor and receiver stall pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_result(out_data);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(16, 200);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= 1'($urandom_range(0, 1));
				2: out_stall <= (stall_left % 4) != 0;
				default: out_stall <= ($urandom_range(0, 9) == 0);
			endcase
		end
	end

	task automatic queue_item(logic [CMD_W-1:0] cmd, logic [CAP_W-1:0] sz);
		in_t t;
		t.command = cmd;
		t.request_size = sz;
		pend_q = {pend_q, t};
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || grant_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_m = v;
		n_cfg++;
	endtask

	function automatic logic [CAP_W-1:0] pick_size(logic [CAP_W-1:0] cap);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return cap;
			2: return (cap > 3) ? cap - CAP_W'($urandom_range(0, 3)) : cap;
			3, 4, 5: return CAP_W'($urandom_range(0, cap / 4));
			6: return CAP_W'($urandom_range(0, cap));
			7: return CAP_W'($urandom_range(cap / 2, cap));
			8: return (cap < SIZE_TOP) ? CAP_W'($urandom_range(cap + 1, SIZE_TOP)) : SIZE_TOP;
			default: return CAP_W'($urandom_range(0, SIZE_TOP));
		endcase
	endfunction

	task automatic random_phase(logic [CAP_W-1:0] cap, int count);
		int p;
		logic [CAP_W-1:0] junk;
		write_capacity(cap);
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			junk = CAP_W'($urandom_range(0, SIZE_TOP));
			if (p < 3)
				queue_item(CMD_RECYCLE, junk);
			else if (p < 5)
				queue_item(CMD_FREE, junk);
			else if (p < 7)
				queue_item(CMD_UNUSED, junk);
			else
				queue_item(CMD_ALLOC, pick_size(cap));
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cap_m = CAP_RESET;
		for (int i = 0; i < NBLK; i++) fill_lvl[i] = '0;
		walk_blk = 0;
		open_cnt = 0;
		gap_left = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset capacity, size extremes, every command
		queue_item(CMD_ALLOC, '0);
		queue_item(CMD_ALLOC, CAP_RESET);
		queue_item(CMD_ALLOC, CAP_RESET + CAP_W'(1));
		queue_item(CMD_ALLOC, SIZE_TOP);
		queue_item(CMD_ALLOC, CAP_W'(1));
		queue_item(CMD_RECYCLE, '1);
		queue_item(CMD_UNUSED, SIZE_TOP);
		queue_item(CMD_FREE, '0);
		wait_idle();

		// directed: capacity one, open every block then run out, zero-size after
		write_capacity(CAP_W'(1));
		for (int i = 0; i <= NBLK; i++) queue_item(CMD_ALLOC, CAP_W'(1));
		queue_item(CMD_ALLOC, '0);
		wait_idle();

		random_phase(SIZE_TOP, 240);
		random_phase(CAP_W'(7), 240);
		random_phase(CAP_W'(1), 200);
		random_phase(CAP_W'($urandom_range(1, 16777216)), 240);
		random_phase(CAP_W'(1000), 240);
		random_phase(CAP_RESET, 240);
		random_phase(CAP_W'($urandom_range(1, 64)), 240);
		random_phase(SIZE_TOP, 240);

		repeat (50) @(negedge clk);
		if (grant_q.size() != 0) n_errors += grant_q.size();
		$display("covered %0d transactions over %0d capacity writes, %0d mismatches",
			n_accepted, n_cfg, n_errors);
		$display("grants %0d, oversize %0d, out of blocks %0d, blocks opened %0d, clears %0d",
			n_grant, n_oversize, n_exhausted, n_opened, n_clear);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: multi_block_bump_allocator_core.f
sv/mbba_pkg.sv
sv/multi_block_bump_allocator_core.sv
sv/mbba_checker.sv
sim/testbench.sv
